// File: design/imu_scalar_kalman_smoother_unit_macros.svh
// Assertion helpers included by the design file that checks its own logic.
`ifndef IMU_SCALAR_KALMAN_SMOOTHER_UNIT_MACROS_SVH
`define IMU_SCALAR_KALMAN_SMOOTHER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IKSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IKSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/iksm_pkg.sv
package iksm_pkg;

  // Field widths of the sample and the result.
  localparam int ACC_W = 16;
  localparam int GYR_W = 23;
  localparam int NOISE_W = 16;
  localparam int VAR_W = 32;
  localparam int GAIN_W = 16;
  localparam int CFG_IDX_W = 3;

  // Uncertainty after a restart: 10.0 in Q16.16.
  localparam logic [VAR_W-1:0] VAR_INIT = 32'd655360;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;

  // Noise register reset values, Q8.8.
  localparam logic [NOISE_W-1:0] ACC_RN_RST = 16'd2048;
  localparam logic [NOISE_W-1:0] ACC_QN_RST = 16'd512;
  localparam logic [NOISE_W-1:0] GYR_RN_RST = 16'd256;
  localparam logic [NOISE_W-1:0] GYR_QN_RST = 16'd77;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACC_RN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_QN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYR_RN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYR_QN = 3'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_PRED,
    ST_DIV,
    ST_MLO,
    ST_MHI,
    ST_MVAR,
    ST_WR,
    ST_FIN
  } seq_state_t;

endpackage

// File: design/iksm_ram.sv
module iksm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: design/imu_scalar_kalman_smoother_unit.sv
// Six independent scalar Kalman filters (three accelerometer and three gyroscope
// axes) share one datapath; each channel's estimate and uncertainty live in a
// small synchronous RAM and are read, updated and written back one channel at a
// time. A sample takes 2*AXES channel passes (read, predict, a restoring gain
// division, the MLO, MHI and MVAR multiply states and a write-back), plus
// taking the sample and handing over the result. The gain division, when it
// runs, is the longest step of a pass. A new sample is taken only while the
// sequencer is idle, even when the previous result still waits.
module imu_scalar_kalman_smoother_unit #(
  parameter int AXES = 3,
  parameter int EST_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [iksm_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [iksm_pkg::NOISE_W-1:0]          cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [iksm_pkg::ACC_W-1:0]     in_accel_x,
  input  logic signed [iksm_pkg::ACC_W-1:0]     in_accel_y,
  input  logic signed [iksm_pkg::ACC_W-1:0]     in_accel_z,
  input  logic signed [iksm_pkg::GYR_W-1:0]     in_gyro_x,
  input  logic signed [iksm_pkg::GYR_W-1:0]     in_gyro_y,
  input  logic signed [iksm_pkg::GYR_W-1:0]     in_gyro_z,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [iksm_pkg::ACC_W-1:0]     out_filt_accel_x,
  output logic signed [iksm_pkg::ACC_W-1:0]     out_filt_accel_y,
  output logic signed [iksm_pkg::ACC_W-1:0]     out_filt_accel_z,
  output logic signed [iksm_pkg::GYR_W-1:0]     out_filt_gyro_x,
  output logic signed [iksm_pkg::GYR_W-1:0]     out_filt_gyro_y,
  output logic signed [iksm_pkg::GYR_W-1:0]     out_filt_gyro_z
);

`include "imu_scalar_kalman_smoother_unit_macros.svh"

  localparam int NCH = 2 * AXES;
  localparam int CHW = $clog2(NCH);
  localparam int AW = $clog2(AXES + 1);
  localparam int EW = iksm_pkg::GYR_W + EST_FRAC_BITS;
  localparam int IW = EW + 1;
  localparam int LOW = IW / 2;
  localparam int HIW = IW - LOW;
  localparam int PW = iksm_pkg::GAIN_W + 1 + IW;
  localparam int VW = iksm_pkg::VAR_W;
  localparam int MW = EW + VW;
  localparam int GW = iksm_pkg::GYR_W;
  localparam int AC = iksm_pkg::ACC_W;

  iksm_pkg::seq_state_t st_r, st_nxt;

  logic [iksm_pkg::NOISE_W-1:0] acc_rn_r, acc_qn_r, gyr_rn_r, gyr_qn_r;
  logic [NCH-1:0]               vld_r;
  logic                         gyro_r;
  logic [AW-1:0]                axis_r;
  logic [3:0]                   cnt_r;
  logic signed [AC-1:0]         acc_z_r [3];
  logic signed [GW-1:0]         gyr_z_r [3];
  logic signed [AC-1:0]         res_acc_r [3];
  logic signed [GW-1:0]         res_gyr_r [3];
  logic [VW-1:0]                p1_r;
  logic [VW:0]                  den_r, rem_r;
  logic [iksm_pkg::GAIN_W-1:0]  k_r;
  logic signed [EW-1:0]         est_r;
  logic signed [IW-1:0]         innov_r, delta_r;
  logic [iksm_pkg::GAIN_W+LOW-1:0] prod_lo_r;
  logic signed [iksm_pkg::GAIN_W+HIW:0] prod_hi_r;
  logic [VW+iksm_pkg::GAIN_W:0] var_prod_r;
  logic                         out_valid_r;
  logic signed [AC-1:0]         out_acc_r [3];
  logic signed [GW-1:0]         out_gyr_r [3];

  logic                         in_acc, out_acc, out_free, last_ch, quick, ram_we, ram_re;
  logic [CHW-1:0]               addr;
  logic [MW-1:0]                ram_rdata;
  logic signed [EW-1:0]         est_rd, est_new;
  logic [VW-1:0]                var_rd, var_new, p1;
  logic [VW:0]                  p1_sum, den;
  logic [VW+1:0]                rem2;
  logic [iksm_pkg::NOISE_W-1:0] qn, rn;
  logic signed [GW-1:0]         z_sel, filt;
  logic signed [IW-1:0]         z_ext, innov;
  logic signed [PW-1:0]         prod_sum;
  logic signed [PW-17:0]        prod_sh;
  logic signed [EW-EST_FRAC_BITS-1:0] est_sh;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_ch  = gyro_r && (axis_r == AW'(AXES - 1));
  assign addr     = gyro_r ? CHW'(AXES) + CHW'(axis_r) : CHW'(axis_r);

  // Channel state memory: estimate above uncertainty.
  iksm_ram #(.WIDTH(MW), .DEPTH(NCH)) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata({est_new, var_new}),
    .re   (ram_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // Entries not written since the last restart read as the restart values.
  assign est_rd = vld_r[addr] ? ram_rdata[MW-1:VW] : '0;
  assign var_rd = vld_r[addr] ? ram_rdata[VW-1:0] : iksm_pkg::VAR_INIT;

  // Predict step with saturation, and the gain denominator.
  always_comb begin
    qn     = gyro_r ? gyr_qn_r : acc_qn_r;
    rn     = gyro_r ? gyr_rn_r : acc_rn_r;
    p1_sum = {1'b0, var_rd} + {9'b0, qn, 8'b0};
    p1     = p1_sum[VW] ? '1 : p1_sum[VW-1:0];
    den    = {1'b0, p1} + {9'b0, rn, 8'b0};
    quick  = (den == '0) || ({1'b0, p1} >= den);
    rem2   = {rem_r, 1'b0};
  end

  // Measurement for the current channel and the innovation.
  always_comb begin
    z_sel = '0;
    if (gyro_r) begin
      priority if (axis_r == AW'(0)) z_sel = gyr_z_r[0];
      else if (axis_r == AW'(1)) z_sel = gyr_z_r[1];
      else z_sel = gyr_z_r[2];
    end else begin
      priority if (axis_r == AW'(0)) z_sel = GW'(acc_z_r[0]);
      else if (axis_r == AW'(1)) z_sel = GW'(acc_z_r[1]);
      else z_sel = GW'(acc_z_r[2]);
    end
    z_ext = IW'(z_sel);
    innov = (z_ext <<< EST_FRAC_BITS) - IW'(est_r);
  end

  // Gain times innovation, truncated toward zero after the Q0.16 shift.
  always_comb begin
    prod_sum = (PW'(prod_hi_r) <<< LOW) + PW'(signed'({1'b0, prod_lo_r}));
    prod_sh  = prod_sum[PW-1:16];
    if (prod_sum[PW-1] && (prod_sum[15:0] != '0)) begin
      prod_sh = prod_sh + 1'b1;
    end
  end

  // Updated estimate and uncertainty, and the integer output.
  always_comb begin
    est_new = est_r + EW'(delta_r);
    var_new = var_prod_r[VW+15:16];
    est_sh  = est_new[EW-1:EST_FRAC_BITS];
    if (est_new[EW-1] && (est_new[EST_FRAC_BITS-1:0] != '0)) begin
      est_sh = est_sh + 1'b1;
    end
    filt = GW'(est_sh);
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      iksm_pkg::ST_IDLE: if (in_valid) st_nxt = iksm_pkg::ST_RD;
      iksm_pkg::ST_RD:   st_nxt = iksm_pkg::ST_PRED;
      iksm_pkg::ST_PRED: st_nxt = quick ? iksm_pkg::ST_MLO : iksm_pkg::ST_DIV;
      iksm_pkg::ST_DIV:  if (cnt_r == 4'd15) st_nxt = iksm_pkg::ST_MLO;
      iksm_pkg::ST_MLO:  st_nxt = iksm_pkg::ST_MHI;
      iksm_pkg::ST_MHI:  st_nxt = iksm_pkg::ST_MVAR;
      iksm_pkg::ST_MVAR: st_nxt = iksm_pkg::ST_WR;
      iksm_pkg::ST_WR:   st_nxt = last_ch ? iksm_pkg::ST_FIN : iksm_pkg::ST_RD;
      iksm_pkg::ST_FIN:  if (out_free) st_nxt = iksm_pkg::ST_IDLE;
      default:           st_nxt = iksm_pkg::ST_IDLE;
    endcase
  end

  // State decoded outputs.
  always_comb begin
    in_stall = (st_r != iksm_pkg::ST_IDLE);
    ram_re   = (st_r == iksm_pkg::ST_RD);
    ram_we   = (st_r == iksm_pkg::ST_WR);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= iksm_pkg::ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      acc_rn_r    <= iksm_pkg::ACC_RN_RST;
      acc_qn_r    <= iksm_pkg::ACC_QN_RST;
      gyr_rn_r    <= iksm_pkg::GYR_RN_RST;
      gyr_qn_r    <= iksm_pkg::GYR_QN_RST;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          iksm_pkg::REG_ACC_RN: acc_rn_r <= cfg_wdata;
          iksm_pkg::REG_ACC_QN: acc_qn_r <= cfg_wdata;
          iksm_pkg::REG_GYR_RN: gyr_rn_r <= cfg_wdata;
          iksm_pkg::REG_GYR_QN: gyr_qn_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc && in_restart) begin
        vld_r <= '0;
      end else if (ram_we) begin
        vld_r[addr] <= 1'b1;
      end
      if (st_r == iksm_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (st_r)
      iksm_pkg::ST_IDLE: begin
        gyro_r     <= 1'b0;
        axis_r     <= '0;
        acc_z_r[0] <= in_accel_x;
        acc_z_r[1] <= in_accel_y;
        acc_z_r[2] <= in_accel_z;
        gyr_z_r[0] <= in_gyro_x;
        gyr_z_r[1] <= in_gyro_y;
        gyr_z_r[2] <= in_gyro_z;
        for (int i = 0; i < 3; i++) begin
          res_acc_r[i] <= '0;
          res_gyr_r[i] <= '0;
        end
      end
      iksm_pkg::ST_PRED: begin
        p1_r  <= p1;
        den_r <= den;
        rem_r <= {1'b0, p1};
        est_r <= est_rd;
        k_r   <= quick ? iksm_pkg::GAIN_MAX : '0;
        cnt_r <= '0;
      end
      iksm_pkg::ST_DIV: begin
        cnt_r <= cnt_r + 4'd1;
        if (rem2 >= {1'b0, den_r}) begin
          rem_r <= (VW+1)'(rem2 - {1'b0, den_r});
          k_r   <= {k_r[iksm_pkg::GAIN_W-2:0], 1'b1};
        end else begin
          rem_r <= rem2[VW:0];
          k_r   <= {k_r[iksm_pkg::GAIN_W-2:0], 1'b0};
        end
      end
      iksm_pkg::ST_MLO: begin
        innov_r   <= innov;
        prod_lo_r <= k_r * innov[LOW-1:0];
      end
      iksm_pkg::ST_MHI: begin
        prod_hi_r <= signed'({1'b0, k_r}) * signed'(innov_r[IW-1:LOW]);
      end
      iksm_pkg::ST_MVAR: begin
        delta_r    <= IW'(prod_sh);
        var_prod_r <= p1_r * ((iksm_pkg::GAIN_W+1)'(1 << iksm_pkg::GAIN_W) - k_r);
      end
      iksm_pkg::ST_WR: begin
        for (int i = 0; i < 3; i++) begin
          if (axis_r == AW'(i)) begin
            if (gyro_r) begin
              res_gyr_r[i] <= filt;
            end else begin
              res_acc_r[i] <= filt[AC-1:0];
            end
          end
        end
        if (axis_r == AW'(AXES - 1)) begin
          gyro_r <= 1'b1;
          axis_r <= '0;
        end else begin
          axis_r <= axis_r + 1'b1;
        end
      end
      iksm_pkg::ST_FIN: begin
        if (out_free) begin
          out_acc_r <= res_acc_r;
          out_gyr_r <= res_gyr_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_filt_accel_x = out_acc_r[0];
  assign out_filt_accel_y = out_acc_r[1];
  assign out_filt_accel_z = out_acc_r[2];
  assign out_filt_gyro_x  = out_gyr_r[0];
  assign out_filt_gyro_y  = out_gyr_r[1];
  assign out_filt_gyro_z  = out_gyr_r[2];

  // Checks on the sequencer and the gain divider.
  `IKSM_ASSERT_NEXT(a_accept_reads, in_acc, st_r == iksm_pkg::ST_RD, "sample taken but no read")
  `IKSM_ASSERT_NOW(a_div_rem, st_r == iksm_pkg::ST_DIV, rem_r < den_r, "divider remainder too big")
  `IKSM_ASSERT_NEXT(a_fin_out, (st_r == iksm_pkg::ST_FIN) && !out_valid_r, out_valid_r, "result lost")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC = 8;
  localparam int HOLD_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;
  localparam int AW_T = iksm_pkg::ACC_W;
  localparam int GW_T = iksm_pkg::GYR_W;
  localparam int VW_T = iksm_pkg::VAR_W;
  localparam int NW_T = iksm_pkg::NOISE_W;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [iksm_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [NW_T-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [AW_T-1:0] in_accel_x, in_accel_y, in_accel_z;
  logic signed [GW_T-1:0] in_gyro_x, in_gyro_y, in_gyro_z;
  logic in_restart;
  logic out_valid;
  logic out_stall;
  logic signed [AW_T-1:0] out_filt_accel_x, out_filt_accel_y, out_filt_accel_z;
  logic signed [GW_T-1:0] out_filt_gyro_x, out_filt_gyro_y, out_filt_gyro_z;

  // One expected filtered sample.
  typedef struct {
    logic signed [AW_T-1:0] acc [3];
    logic signed [GW_T-1:0] gyr [3];
  } filt_sample_t;

  filt_sample_t filt_queue[$];

  // Predictor state and noise settings.
  logic [NW_T-1:0] acc_rn, acc_qn, gyr_rn, gyr_qn;
  longint acc_state [3];
  longint gyr_state [3];
  logic [VW_T-1:0] acc_unc [3];
  logic [VW_T-1:0] gyr_unc [3];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int quiet_cycles;
  bit failed;

  imu_scalar_kalman_smoother_unit i_dut (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Restore the fresh-filter state on every channel.
  task automatic restart_filters();
    for (int i = 0; i < 3; i++) begin
      acc_state[i] = 0;
      gyr_state[i] = 0;
      acc_unc[i] = iksm_pkg::VAR_INIT;
      gyr_unc[i] = iksm_pkg::VAR_INIT;
    end
  endtask

  // One scalar Kalman update of a channel; returns the truncated integer estimate.
  function automatic longint kalman_update(inout longint est, inout logic [VW_T-1:0] unc,
                                           input longint z, input logic [NW_T-1:0] qn,
                                           input logic [NW_T-1:0] rn);
    logic [63:0] p1;
    logic [63:0] den;
    logic [63:0] gain;
    longint innov;
    longint delta;
    p1 = 64'(unc) + (64'(qn) << 8);
    if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
    den = p1 + (64'(rn) << 8);
    if (den == 0) begin
      gain = 64'd65535;
    end else begin
      gain = (p1 << 16) / den;
      if (gain > 64'd65535) gain = 64'd65535;
    end
    innov = z * (longint'(1) << FRAC) - est;
    delta = (longint'(gain) * innov) / 65536;
    est = est + delta;
    unc = VW_T'((p1 * (64'd65536 - gain)) >> 16);
    return est / (longint'(1) << FRAC);
  endfunction

  // Work out the filtered sample for the transaction that has just been accepted.
  task automatic predict_filtered();
    filt_sample_t exp_s;
    longint za [3];
    longint zg [3];
    za[0] = in_accel_x; za[1] = in_accel_y; za[2] = in_accel_z;
    zg[0] = in_gyro_x; zg[1] = in_gyro_y; zg[2] = in_gyro_z;
    if (in_restart) restart_filters();
    for (int i = 0; i < 3; i++) begin
      exp_s.acc[i] = AW_T'(kalman_update(acc_state[i], acc_unc[i], za[i], acc_qn, acc_rn));
      exp_s.gyr[i] = GW_T'(kalman_update(gyr_state[i], gyr_unc[i], zg[i], gyr_qn, gyr_rn));
    end
    filt_queue.push_back(exp_s);
  endtask

  // Offer one sample and hold it until the block takes it; valid drops while idling.
  task automatic send_sample(input logic signed [AW_T-1:0] ax, ay, az,
                             input logic signed [GW_T-1:0] gx, gy, gz, input bit rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= ax; in_accel_y <= ay; in_accel_z <= az;
    in_gyro_x <= gx; in_gyro_y <= gy; in_gyro_z <= gz;
    in_restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_filtered();
  endtask

  task automatic send_random(input bit allow_restart);
    send_sample(AW_T'($urandom), AW_T'($urandom), AW_T'($urandom),
                GW_T'($urandom), GW_T'($urandom), GW_T'($urandom),
                allow_restart && ($urandom_range(19) == 0));
  endtask

  // Wait until every filtered sample has arrived and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (filt_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_reg(input logic [iksm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [NW_T-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      iksm_pkg::REG_ACC_RN: acc_rn = val;
      iksm_pkg::REG_ACC_QN: acc_qn = val;
      iksm_pkg::REG_GYR_RN: gyr_rn = val;
      iksm_pkg::REG_GYR_QN: gyr_qn = val;
      default: ;
    endcase
  endtask

  task automatic set_noise(input logic [NW_T-1:0] arn, aqn, grn, gqn);
    write_reg(iksm_pkg::REG_ACC_RN, arn);
    write_reg(iksm_pkg::REG_ACC_QN, aqn);
    write_reg(iksm_pkg::REG_GYR_RN, grn);
    write_reg(iksm_pkg::REG_GYR_QN, gqn);
    cfg_we <= 1'b0;
  endtask

  // Field extremes, restarts and sign changes at the reset noise settings.
  task automatic test_extremes();
    send_sample(16'sh7FFF, 16'sh8000, 16'sd0, 23'sh3FFFFF, 23'sh400000, 23'sd0, 1'b1);
    send_sample(16'sh8000, 16'sh7FFF, -16'sd1, 23'sh400000, 23'sh3FFFFF, 23'sd1, 1'b0);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 23'sh3FFFFF, 23'sh3FFFFF, 23'sh3FFFFF, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 23'sh400000, 23'sh400000, 23'sh400000, 1'b0);
    send_sample(-16'sd1, -16'sd1, -16'sd1, -23'sd1, -23'sd1, -23'sd1, 1'b1);
    send_sample(16'sd0, 16'sd0, 16'sd0, 23'sd0, 23'sd0, 23'sd0, 1'b0);
    send_sample(16'sd1, -16'sd1, 16'sh5555, 23'sd1, -23'sd1, 23'sh2AAAAA, 1'b0);
    send_sample(16'shAAAA, 16'sh5555, 16'sd3, 23'sh555555, 23'sh2AAAAA, 23'sd5, 1'b1);
    drain();
  endtask

  // Noise settings at their extremes: zero R caps the gain.
  task automatic test_noise_extremes();
    set_noise(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_random(i == 0);
    drain();
    set_noise(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    for (int i = 0; i < 5; i++) send_random(i == 0);
    drain();
    set_noise(16'd1, 16'd0, 16'd1, 16'd0);
    for (int i = 0; i < 5; i++) send_random(i == 0);
    drain();
  endtask

  // Random samples at random noise settings, over the three idling patterns.
  task automatic test_random_traffic();
    int phase_send [3] = '{16, 80, 0};
    int phase_recv [3] = '{80, 16, 0};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = phase_send[ph];
      recv_idle_pct = phase_recv[ph];
      set_noise(NW_T'($urandom), NW_T'($urandom_range(4095)), NW_T'($urandom),
                NW_T'($urandom_range(255)));
      for (int i = 0; i < 140; i++) send_random(1'b1);
      drain();
    end
  endtask

  // Receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 600;
    for (int i = 0; i < 8; i++) send_random(1'b0);
    drain();
  endtask

  // Stimulus sequence.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_accel_x = '0; in_accel_y = '0; in_accel_z = '0;
    in_gyro_x = '0; in_gyro_y = '0; in_gyro_z = '0;
    in_restart = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    failed = 1'b0;
    acc_rn = iksm_pkg::ACC_RN_RST; acc_qn = iksm_pkg::ACC_QN_RST;
    gyr_rn = iksm_pkg::GYR_RN_RST; gyr_qn = iksm_pkg::GYR_QN_RST;
    restart_filters();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_noise_extremes();
    test_backpressure();
    test_random_traffic();
    set_noise(iksm_pkg::ACC_RN_RST, iksm_pkg::ACC_QN_RST, iksm_pkg::GYR_RN_RST,
              iksm_pkg::GYR_QN_RST);
    for (int i = 0; i < 20; i++) send_random(1'b1);
    drain();
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver stall, with a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial out_stall = 1'b0;

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    filt_sample_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (filt_queue.size() == 0) begin
        $display("%0t: result with no expectation waiting", $time);
        failed = 1'b1;
      end else begin
        exp_s = filt_queue.pop_front();
        if (out_filt_accel_x !== exp_s.acc[0] || out_filt_accel_y !== exp_s.acc[1] ||
            out_filt_accel_z !== exp_s.acc[2]) begin
          $display("%0t: accel expected %0d %0d %0d actual %0d %0d %0d", $time,
                   exp_s.acc[0], exp_s.acc[1], exp_s.acc[2],
                   out_filt_accel_x, out_filt_accel_y, out_filt_accel_z);
          failed = 1'b1;
        end
        if (out_filt_gyro_x !== exp_s.gyr[0] || out_filt_gyro_y !== exp_s.gyr[1] ||
            out_filt_gyro_z !== exp_s.gyr[2]) begin
          $display("%0t: gyro expected %0d %0d %0d actual %0d %0d %0d", $time,
                   exp_s.gyr[0], exp_s.gyr[1], exp_s.gyr[2],
                   out_filt_gyro_x, out_filt_gyro_y, out_filt_gyro_z);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HOLD_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial quiet_cycles = 0;

endmodule

// File: imu_scalar_kalman_smoother_unit.f
+incdir+design
design/iksm_pkg.sv
design/iksm_ram.sv
design/imu_scalar_kalman_smoother_unit.sv
tb/sv/tb_top.sv
